FILE: src/sidu_pkg.sv
// ----------------------------------------------------------------------------
// sidu_pkg: shared types and constants for the sorted key set unit
// Action codes, result status codes, per-cell operation codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sidu_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DELETE = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_LISTED    = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_cell_op          op;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  head_key;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: src/sidu_cell.sv
// ----------------------------------------------------------------------------
// sidu_cell: one slot of the sorted key chain
// Holds a key, compares it against the request and takes the request key or a neighbor's
// key when the chain opens a gap (insert), closes one (delete) or rotates (dump).
// ----------------------------------------------------------------------------
`default_nettype none

module sidu_cell (
    input  wire                          i_clk,
    input  wire sidu_pkg::t_cell_ctrl    i_ctrl,
    input  wire                          i_valid,     // slot holds a stored key
    input  wire                          i_top,       // highest occupied slot
    input  wire                          i_prev_lt,   // lower neighbor is below request
    input  wire [sidu_pkg::KEY_W-1:0]    i_prev_key,
    input  wire [sidu_pkg::KEY_W-1:0]    i_next_key,
    output logic [sidu_pkg::KEY_W-1:0]   o_key,
    output logic                         o_lt,
    output logic                         o_eq
);

    logic [sidu_pkg::KEY_W-1:0] r_key;
    logic [sidu_pkg::KEY_W-1:0] n_key;

    assign o_key = r_key;
    assign o_lt  = i_valid && ($signed(r_key) < $signed(i_ctrl.key));
    assign o_eq  = i_valid && (r_key == i_ctrl.key);

    always_comb begin
        n_key = r_key;
        case (i_ctrl.op)
            sidu_pkg::CELL_INSERT: begin
                if (!o_lt) begin
                    n_key = i_prev_lt ? i_ctrl.key : i_prev_key;
                end
            end
            sidu_pkg::CELL_DELETE: begin
                if (!o_lt) begin
                    n_key = i_next_key;
                end
            end
            sidu_pkg::CELL_ROTATE: begin
                n_key = i_top ? i_ctrl.head_key : i_next_key;
            end
            default: n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

FILE: src/sorted_id_set_insert_delete_unit.sv
// Insert/delete: a taken request is answered from S_EXEC into the output register.
// A new request is taken only in S_IDLE, once the last is answered; in S_DUMP one stored
//   key leaves the head of the rotating cell chain per cycle while the output is free.
// Output stalls hold the controller until the output register frees up.
// Reset (synchronous, active low) empties the set; stored keys are not cleared.
// ----------------------------------------------------------------------------
// sorted_id_set_insert_delete_unit: sorted key set over a chain of cells
// Every cell compares in parallel; inserts and deletes shift the chain by one.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_set_insert_delete_unit #(
    parameter int CAPACITY = sidu_pkg::CAPACITY_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire [31:0]                      i_s_axis_tdata,  // [31:0] student_id
    input  wire [1:0]                       i_s_axis_tuser,  // [1:0] action
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,  // [31:0] entry_id
    output logic [2:0]                      o_m_axis_tuser,  // [2:0] status
    output logic                            o_m_axis_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = sidu_pkg::KEY_W;

    sidu_pkg::t_state r_state, n_state;

    logic [sidu_pkg::ACTION_W-1:0] r_act;
    logic [KW-1:0]                 r_req;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_idx, n_idx;

    logic                          r_out_valid, n_out_valid;
    logic [KW-1:0]                 r_out_key, n_out_key;
    logic [sidu_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic                          r_out_last, n_out_last;

    sidu_pkg::t_cell_ctrl          w_ctrl;
    sidu_pkg::t_cell_op            w_op;

    logic [KW-1:0]   w_key  [CAPACITY];
    logic [CAPACITY-1:0] w_lt, w_eq, w_valid, w_top;
    logic            w_found, w_full, w_out_free, w_dump_last;

    assign w_found     = |w_eq;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_dump_last = ((r_idx + 1'b1) == r_count);

    assign o_s_axis_tready = (r_state == sidu_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_key;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    assign w_ctrl.op       = w_op;
    assign w_ctrl.key      = r_req;
    assign w_ctrl.head_key = w_key[0];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_valid[g] = (CW'(g) < r_count);
            if (g == CAPACITY - 1) begin : g_end
                assign w_top[g] = w_valid[g];
            end else begin : g_mid
                assign w_top[g] = w_valid[g] && !w_valid[g+1];
            end

            logic          w_prev_lt;
            logic [KW-1:0] w_prev_key, w_next_key;
            if (g == 0) begin : g_lo
                assign w_prev_lt  = 1'b1;
                assign w_prev_key = r_req;
            end else begin : g_lo_n
                assign w_prev_lt  = w_lt[g-1];
                assign w_prev_key = w_key[g-1];
            end
            if (g == CAPACITY - 1) begin : g_hi
                assign w_next_key = w_key[g];
            end else begin : g_hi_n
                assign w_next_key = w_key[g+1];
            end

            sidu_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_valid    (w_valid[g]),
                .i_top      (w_top[g]),
                .i_prev_lt  (w_prev_lt),
                .i_prev_key (w_prev_key),
                .i_next_key (w_next_key),
                .o_key      (w_key[g]),
                .o_lt       (w_lt[g]),
                .o_eq       (w_eq[g])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sidu_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) n_state = sidu_pkg::S_EXEC;
            end
            sidu_pkg::S_EXEC: begin
                if (r_act == sidu_pkg::ACT_NONE) begin
                    n_state = sidu_pkg::S_IDLE;
                end else if (r_act == sidu_pkg::ACT_DUMP && r_count != '0) begin
                    n_state = sidu_pkg::S_DUMP;
                end else if (w_out_free) begin
                    n_state = sidu_pkg::S_IDLE;
                end
            end
            sidu_pkg::S_DUMP: begin
                if (w_out_free && w_dump_last) n_state = sidu_pkg::S_IDLE;
            end
            default: n_state = sidu_pkg::S_IDLE;
        endcase
    end

    // Outputs, cell control and counters
    always_comb begin
        w_op         = sidu_pkg::CELL_HOLD;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        unique case (r_state)
            sidu_pkg::S_IDLE: begin
                n_idx = '0;
            end
            sidu_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_out_key  = r_req;
                    n_out_last = 1'b1;
                    case (r_act)
                        sidu_pkg::ACT_INSERT: begin
                            n_out_valid = 1'b1;
                            if (w_found) begin
                                n_out_status = sidu_pkg::ST_DUPLICATE;
                            end else if (w_full) begin
                                n_out_status = sidu_pkg::ST_FULL;
                            end else begin
                                n_out_status = sidu_pkg::ST_INSERTED;
                                w_op         = sidu_pkg::CELL_INSERT;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        sidu_pkg::ACT_DELETE: begin
                            n_out_valid = 1'b1;
                            if (w_found) begin
                                n_out_status = sidu_pkg::ST_DELETED;
                                w_op         = sidu_pkg::CELL_DELETE;
                                n_count      = r_count - 1'b1;
                            end else begin
                                n_out_status = sidu_pkg::ST_NOT_FOUND;
                            end
                        end
                        sidu_pkg::ACT_DUMP: begin
                            // only the empty case is answered here
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_key    = '0;
                                n_out_status = sidu_pkg::ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sidu_pkg::S_DUMP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = w_key[0];
                    n_out_status = sidu_pkg::ST_LISTED;
                    n_out_last   = w_dump_last;
                    w_op         = sidu_pkg::CELL_ROTATE;
                    n_idx        = r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sidu_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sidu_pkg::S_IDLE && i_s_axis_tvalid) begin
            r_act <= i_s_axis_tuser;
            r_req <= i_s_axis_tdata;
        end
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

endmodule

`default_nettype wire

FILE: verif/sorted_id_set_insert_delete_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_set_insert_delete_unit_tb: self-checking bench for the sorted key set
// A short directed table covers the empty store, the extreme keys, duplicates
// and misses. It is followed by random fill, drain and mixed bursts under four
// idle/stall mixes. A queue-based copy of the set predicts the results the table does not type.
// ----------------------------------------------------------------------------

module sorted_id_set_insert_delete_unit_tb;

    localparam int SET_CAP        = sidu_pkg::CAPACITY_DEF;
    localparam int PHASE_ITEMS    = 55;
    localparam int DRAIN_CYCLES   = SET_CAP + 16;   // longest dump plus pipeline
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int N_DIRECTED     = 23;

    typedef struct {
        logic [31:0]       entry_id;
        sidu_pkg::t_status status;
        logic              last;
    } t_id_result;

    typedef struct {
        sidu_pkg::t_action act;
        logic [31:0]       key;
        bit                typed;
        sidu_pkg::t_status typed_status;
    } t_directed_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        src_valid   = 1'b0;
    logic [1:0]  src_action  = sidu_pkg::ACT_NONE;
    logic [31:0] src_key     = 32'h0;
    logic        sink_ready  = 1'b0;

    wire         src_ready;
    wire         res_valid;
    wire [31:0]  res_entry_id;
    wire [2:0]   res_status;
    wire         res_last;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;

    int          stored_ids[$];       // predicted contents, ascending
    t_id_result  step_results[$];     // results of the request just taken
    t_id_result  pending_results[$];  // results not yet seen on the output

    t_directed_row directed_rows [N_DIRECTED];

    sorted_id_set_insert_delete_unit #(
        .CAPACITY (SET_CAP)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_key),      // [31:0] student_id
        .i_s_axis_tuser  (src_action),   // [1:0] action
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (res_entry_id), // [31:0] entry_id
        .o_m_axis_tuser  (res_status),   // [2:0] status
        .o_m_axis_tlast  (res_last)
    );

    always #5 i_clk = ~i_clk;

    // Updates the predicted set and fills step_results for one request.
    function automatic void apply_set_request(input sidu_pkg::t_action act,
                                              input logic [31:0] key_bits);
        int key;
        int pos;
        key = key_bits;
        pos = 0;
        step_results.delete();
        case (act)
            sidu_pkg::ACT_DUMP: begin
                if (stored_ids.size() == 0) begin
                    step_results.push_back('{32'h0, sidu_pkg::ST_EMPTY, 1'b1});
                end else begin
                    foreach (stored_ids[i])
                        step_results.push_back('{stored_ids[i], sidu_pkg::ST_LISTED,
                                                 i == stored_ids.size() - 1});
                end
            end
            sidu_pkg::ACT_INSERT, sidu_pkg::ACT_DELETE: begin
                while (pos < stored_ids.size() && stored_ids[pos] < key)
                    pos++;
                if (act == sidu_pkg::ACT_INSERT) begin
                    // duplicate wins over full
                    if (pos < stored_ids.size() && stored_ids[pos] == key) begin
                        step_results.push_back('{key_bits, sidu_pkg::ST_DUPLICATE, 1'b1});
                    end else if (stored_ids.size() >= SET_CAP) begin
                        step_results.push_back('{key_bits, sidu_pkg::ST_FULL, 1'b1});
                    end else begin
                        stored_ids.insert(pos, key);
                        step_results.push_back('{key_bits, sidu_pkg::ST_INSERTED, 1'b1});
                    end
                end else if (pos < stored_ids.size() && stored_ids[pos] == key) begin
                    stored_ids.delete(pos);
                    step_results.push_back('{key_bits, sidu_pkg::ST_DELETED, 1'b1});
                end else begin
                    step_results.push_back('{key_bits, sidu_pkg::ST_NOT_FOUND, 1'b1});
                end
            end
            default: ;  // unused code: no change, no result
        endcase
    endfunction

    function automatic logic [31:0] random_key();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1:       return $urandom_range(16) - 32'd8;  // small keys around zero
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] existing_key();
        if (stored_ids.size() == 0)
            return random_key();
        return stored_ids[$urandom_range(stored_ids.size() - 1)];
    endfunction

    // Drives one request, waits for the handshake, then records what it should produce.
    task automatic send_request(input sidu_pkg::t_action act, input logic [31:0] key,
                                input bit typed, input sidu_pkg::t_status typed_status);
        while ($urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge i_clk);
        end
        src_valid  <= 1'b1;
        src_action <= act;
        src_key    <= key;
        @(posedge i_clk);
        while (!src_ready)
            @(posedge i_clk);
        apply_set_request(act, key);
        if (typed)
            pending_results.push_back('{(act == sidu_pkg::ACT_DUMP) ? 32'h0 : key,
                                        typed_status, 1'b1});
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    // Stops sending until every outstanding result has come back.
    task automatic wait_results_drained();
        src_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    task automatic run_random_phase(input int n_items, input bit force_fill);
        int                sent;
        int                kind;
        int                burst;
        sidu_pkg::t_action act;
        sent = 0;
        while (sent < n_items) begin
            kind = (sent == 0 && force_fill) ? 0 : $urandom_range(99);
            if (kind < 20) begin
                // fill to capacity, hit the full store with a duplicate and a new key, then dump
                while (stored_ids.size() < SET_CAP) begin
                    send_request(sidu_pkg::ACT_INSERT, random_key(), 1'b0,
                                 sidu_pkg::ST_INSERTED);
                    sent++;
                end
                send_request(sidu_pkg::ACT_INSERT, existing_key(), 1'b0, sidu_pkg::ST_INSERTED);
                send_request(sidu_pkg::ACT_INSERT, $urandom(), 1'b0, sidu_pkg::ST_INSERTED);
                send_request(sidu_pkg::ACT_DUMP, $urandom(), 1'b0, sidu_pkg::ST_INSERTED);
                sent += 3;
            end else if (kind < 35) begin
                while (stored_ids.size() > 0) begin
                    send_request(sidu_pkg::ACT_DELETE, existing_key(), 1'b0,
                                 sidu_pkg::ST_INSERTED);
                    sent++;
                end
                send_request(sidu_pkg::ACT_DELETE, random_key(), 1'b0, sidu_pkg::ST_INSERTED);
                send_request(sidu_pkg::ACT_DUMP, $urandom(), 1'b0, sidu_pkg::ST_INSERTED);
                sent += 2;
            end else begin
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    kind = $urandom_range(99);
                    if (kind < 40)      act = sidu_pkg::ACT_INSERT;
                    else if (kind < 75) act = sidu_pkg::ACT_DELETE;
                    else if (kind < 92) act = sidu_pkg::ACT_DUMP;
                    else                act = sidu_pkg::ACT_NONE;
                    send_request(act, (act == sidu_pkg::ACT_DELETE && kind < 55)
                                      ? existing_key() : random_key(),
                                 1'b0, sidu_pkg::ST_INSERTED);
                    if (act != sidu_pkg::ACT_NONE)
                        sent++;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Output side: random backpressure and in-order checking.
    always @(posedge i_clk) begin
        t_id_result exp_r;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (res_valid && sink_ready) begin
                if (pending_results.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h/%0d/%b",
                                 $time, res_entry_id, res_status, res_last);
                    mismatch_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (res_entry_id !== exp_r.entry_id)
                        report_mismatch("entry_id", exp_r.entry_id, res_entry_id);
                    if (res_status !== exp_r.status)
                        report_mismatch("status", 32'(exp_r.status), 32'(res_status));
                    if (res_last !== exp_r.last)
                        report_mismatch("last", 32'(exp_r.last), 32'(res_last));
                end
            end
            sink_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Ends a hung run: too many cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((src_valid && src_ready) || (res_valid && sink_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        directed_rows = '{
            '{sidu_pkg::ACT_DUMP,   32'h0000_0000, 1'b1, sidu_pkg::ST_EMPTY},
            '{sidu_pkg::ACT_DELETE, 32'h0000_0005, 1'b1, sidu_pkg::ST_NOT_FOUND},  // empty store
            '{sidu_pkg::ACT_INSERT, 32'h7FFF_FFFF, 1'b1, sidu_pkg::ST_INSERTED},   // empty store
            '{sidu_pkg::ACT_INSERT, 32'h8000_0000, 1'b1, sidu_pkg::ST_INSERTED},
            '{sidu_pkg::ACT_INSERT, 32'h0000_0000, 1'b1, sidu_pkg::ST_INSERTED},
            '{sidu_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b1, sidu_pkg::ST_INSERTED},
            '{sidu_pkg::ACT_INSERT, 32'h0000_0001, 1'b1, sidu_pkg::ST_INSERTED},
            '{sidu_pkg::ACT_INSERT, 32'h7FFF_FFFF, 1'b1, sidu_pkg::ST_DUPLICATE},
            '{sidu_pkg::ACT_INSERT, 32'h8000_0000, 1'b1, sidu_pkg::ST_DUPLICATE},
            '{sidu_pkg::ACT_DUMP,   32'h0000_0000, 1'b0, sidu_pkg::ST_LISTED},
            '{sidu_pkg::ACT_NONE,   32'hAAAA_AAAA, 1'b0, sidu_pkg::ST_LISTED},     // no result
            '{sidu_pkg::ACT_DELETE, 32'h8000_0000, 1'b1, sidu_pkg::ST_DELETED},
            '{sidu_pkg::ACT_DELETE, 32'h8000_0000, 1'b1, sidu_pkg::ST_NOT_FOUND},
            '{sidu_pkg::ACT_DELETE, 32'h5555_5555, 1'b1, sidu_pkg::ST_NOT_FOUND},
            '{sidu_pkg::ACT_DUMP,   32'hFFFF_FFFF, 1'b0, sidu_pkg::ST_LISTED},
            '{sidu_pkg::ACT_DELETE, 32'h7FFF_FFFF, 1'b1, sidu_pkg::ST_DELETED},
            '{sidu_pkg::ACT_DELETE, 32'h0000_0000, 1'b1, sidu_pkg::ST_DELETED},
            '{sidu_pkg::ACT_DELETE, 32'hFFFF_FFFF, 1'b1, sidu_pkg::ST_DELETED},
            '{sidu_pkg::ACT_DELETE, 32'h0000_0001, 1'b1, sidu_pkg::ST_DELETED},
            '{sidu_pkg::ACT_DUMP,   32'h0000_0000, 1'b1, sidu_pkg::ST_EMPTY},
            '{sidu_pkg::ACT_INSERT, 32'h1234_5678, 1'b1, sidu_pkg::ST_INSERTED},
            '{sidu_pkg::ACT_DUMP,   32'h0000_0000, 1'b0, sidu_pkg::ST_LISTED},     // single entry
            '{sidu_pkg::ACT_DELETE, 32'h1234_5678, 1'b1, sidu_pkg::ST_DELETED}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].key,
                         directed_rows[i].typed, directed_rows[i].typed_status);

        for (int phase = 0; phase < 4; phase++) begin
            wait_results_drained();
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 57; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 57; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            run_random_phase(PHASE_ITEMS, phase % 2 == 0);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sorted_id_set_insert_delete_unit.f
src/sidu_pkg.sv
src/sidu_cell.sv
src/sorted_id_set_insert_delete_unit.sv
verif/sorted_id_set_insert_delete_unit_tb.sv
